// ----- rtl/dbtt_pkg.sv -----
// dbtt_pkg: shared types and constants of the two-bank tape transport control block
// no dependencies; used by dbtt_chan users and by double_buffer_tape_transport
package dbtt_pkg;

  localparam int BANK_DEPTH   = 131072;
  localparam int XFADE_LEN    = 64;
  localparam int XFADE_MAX    = XFADE_LEN + 3;
  localparam int MIN_PLAY_LEN = 4;
  localparam int DECIM_MAX    = 16;

  localparam int POS_W   = 18;
  localparam int SEL_W   = 17;
  localparam int DECIM_W = 5;
  localparam int XLEN_W  = 7;

  // command codes
  localparam logic [2:0] CMD_PLAY      = 3'd0;
  localparam logic [2:0] CMD_STOP_PLAY = 3'd1;
  localparam logic [2:0] CMD_RECORD    = 3'd2;
  localparam logic [2:0] CMD_STOP_REC  = 3'd3;
  localparam logic [2:0] CMD_SLICE     = 3'd4;

  // configuration register indexes
  localparam logic CFG_REVERSE    = 1'b0;
  localparam logic CFG_DECIMATION = 1'b1;

  // record phase codes seen on the result
  localparam logic [1:0] REC_CODE_IDLE  = 2'd0;
  localparam logic [1:0] REC_CODE_REC   = 2'd1;
  localparam logic [1:0] REC_CODE_DONE  = 2'd2;
  localparam logic [1:0] REC_CODE_REREC = 2'd3;

  typedef enum logic [1:0] {
    PLAY_HALTED  = 2'b01,
    PLAY_RUNNING = 2'b10
  } play_st_t;

  typedef enum logic [3:0] {
    REC_OFF    = 4'b0001,
    REC_ACTIVE = 4'b0010,
    REC_TAKEN  = 4'b0100,
    REC_RETAKE = 4'b1000
  } rec_st_t;

  typedef struct packed {
    logic [2:0]       cmd;
    logic [POS_W-1:0] rec_head;
    logic [POS_W-1:0] play_pos;
    logic [SEL_W-1:0] slice_sel;
  } item_t;

  typedef struct packed {
    logic               playing;
    logic [1:0]         rec_phase;
    logic               playback_bank;
    logic               bank_swapped;
    logic               head_set;
    logic [POS_W-1:0]   head_pos;
    logic               note_on;
    logic               xfade_arm;
    logic [POS_W-1:0]   xfade_start;
    logic [XLEN_W-1:0]  xfade_len;
    logic               rec_head_clear;
    logic [DECIM_W-1:0] play_decimation;
  } result_t;

endpackage

// ----- rtl/dbtt_chan.sv -----
// dbtt_chan: valid/ready channel carrying one payload of type T
// no dependencies; instantiated with dbtt_pkg::item_t or dbtt_pkg::result_t
interface dbtt_chan #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/double_buffer_tape_transport.sv -----
// double_buffer_tape_transport: play/record control of a two-bank sampler
// depends on dbtt_pkg and the dbtt_chan interface
//
// One command is taken per cycle while the output can advance, and each gives one result; a
// result passes through the middle-stage register s1 and then the output register res_q. Bank
// lengths, decimation and slice counts live in registers; the slice marks of both banks sit
// in one synchronous memory whose registered read forms the middle stage, so the rate is set
// by that read port: one item per cycle while the result side takes them. Commands write marks
// only into the record bank and read them only from the playback bank, and a write lands
// before any later read, so no forwarding is needed. Entries beyond a bank's slice count are
// never read, which makes a clearing pass after reset unnecessary. Configuration may be written
// whenever the block is empty.
module double_buffer_tape_transport #(
  parameter int SLICE_SLOTS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  dbtt_chan.sink                       item,
  dbtt_chan.source                     result,
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [dbtt_pkg::DECIM_W-1:0] cfg_data
);

  localparam int CNT_W  = $clog2(SLICE_SLOTS + 1);
  localparam int IDX_W  = (SLICE_SLOTS > 1) ? $clog2(SLICE_SLOTS) : 1;
  localparam int ADDR_W = IDX_W + 1;
  localparam int PROD_W = dbtt_pkg::SEL_W + CNT_W;
  localparam int POS_W  = dbtt_pkg::POS_W;

  typedef struct packed {
    dbtt_pkg::result_t res;
    logic              place;   // head comes from a slice mark
    logic              none;    // bank has no marks, mark reads as zero
    logic [POS_W-1:0]  valid;
  } s1_t;

  // control and bank state
  dbtt_pkg::play_st_t           play_st, play_next;
  dbtt_pkg::rec_st_t            rec_st, rec_next;
  logic                         swap_pending, pend_next;
  logic                         play_bank, pb_next;
  logic [POS_W-1:0]             vcnt [2];
  logic [POS_W-1:0]             vcnt_next [2];
  logic [dbtt_pkg::DECIM_W-1:0] decim_bank [2];
  logic [dbtt_pkg::DECIM_W-1:0] decim_next [2];
  logic [CNT_W-1:0]             scnt [2];
  logic [CNT_W-1:0]             scnt_next [2];
  logic                         reverse;
  logic [dbtt_pkg::DECIM_W-1:0] decimation;

  // slice mark memory
  logic [POS_W-1:0]  marks [2**ADDR_W];
  logic              mk_we;
  logic [ADDR_W-1:0] mk_waddr;
  logic [POS_W-1:0]  mk_wdata;
  logic [ADDR_W-1:0] rd_addr;
  logic [POS_W-1:0]  rd_data;

  // pipeline
  logic              adv, accept;
  logic              s1_valid;
  s1_t               s1, s1_next;
  logic              out_valid;
  dbtt_pkg::result_t res_q, res_d;

  // stage 0 scratch
  dbtt_pkg::item_t   it;
  logic              pb, rb;
  logic [POS_W-1:0]  rhead;
  logic [POS_W-1:0]  xstart, avail, nvalid;
  logic [CNT_W-1:0]  cnt, cm1, nmark;
  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] vidx;
  logic [IDX_W-1:0]  idx;

  // stage 1 scratch
  logic [POS_W-1:0]  sp;

  assign adv          = !out_valid || result.ready;
  assign accept       = item.valid && adv;
  assign item.ready   = adv;
  assign result.valid = out_valid;
  assign result.data  = res_q;
  assign it           = item.data;

  always_comb begin
    pb        = play_bank;
    rb        = ~play_bank;
    play_next = play_st;
    rec_next  = rec_st;
    pend_next = swap_pending;
    pb_next   = play_bank;
    for (int b = 0; b < 2; b++) begin
      vcnt_next[b]  = vcnt[b];
      decim_next[b] = decim_bank[b];
      scnt_next[b]  = scnt[b];
    end
    mk_we    = 1'b0;
    mk_waddr = {rb, {IDX_W{1'b0}}};
    mk_wdata = POS_W'(1);
    s1_next  = '0;
    rhead    = (32'(it.rec_head) > dbtt_pkg::BANK_DEPTH) ?
               POS_W'(dbtt_pkg::BANK_DEPTH) : it.rec_head;
    xstart   = it.play_pos - POS_W'(1);
    avail    = (vcnt[pb] > xstart) ? (vcnt[pb] - xstart) : '0;
    nmark    = scnt[rb];
    nvalid   = vcnt[pb];

    if (accept) begin
      case (it.cmd)
        dbtt_pkg::CMD_PLAY: begin
          if (play_st == dbtt_pkg::PLAY_RUNNING) begin
            // retrigger: crossfade out of the old bank
            s1_next.res.xfade_arm   = 1'b1;
            s1_next.res.xfade_start = xstart;
            s1_next.res.xfade_len   = (avail < POS_W'(dbtt_pkg::XFADE_MAX)) ?
                                      dbtt_pkg::XLEN_W'(avail) :
                                      dbtt_pkg::XLEN_W'(dbtt_pkg::XFADE_MAX);
          end
          if (swap_pending) begin
            pb_next                    = ~play_bank;
            pend_next                  = 1'b0;
            s1_next.res.bank_swapped   = 1'b1;
            s1_next.res.rec_head_clear = 1'b1;
            case (rec_st)
              dbtt_pkg::REC_TAKEN: rec_next = dbtt_pkg::REC_OFF;
              dbtt_pkg::REC_RETAKE: begin
                // old playback bank becomes the record bank
                decim_next[pb] = decimation;
                scnt_next[pb]  = CNT_W'(1);
                mk_we          = 1'b1;
                mk_waddr       = {pb, {IDX_W{1'b0}}};
                mk_wdata       = POS_W'(1);
                rec_next       = dbtt_pkg::REC_ACTIVE;
              end
              default: ;
            endcase
          end
          nvalid = vcnt[pb_next];
          if (play_st == dbtt_pkg::PLAY_RUNNING ||
              nvalid >= POS_W'(dbtt_pkg::MIN_PLAY_LEN)) begin
            s1_next.res.note_on = 1'b1;
            play_next           = dbtt_pkg::PLAY_RUNNING;
            if (reverse) begin
              s1_next.res.head_set = 1'b1;
              s1_next.res.head_pos = (nvalid != '0) ? nvalid - POS_W'(1) : '0;
            end else begin
              s1_next.place = 1'b1;
            end
          end
        end
        dbtt_pkg::CMD_STOP_PLAY: play_next = dbtt_pkg::PLAY_HALTED;
        dbtt_pkg::CMD_RECORD: begin
          case (rec_st)
            dbtt_pkg::REC_OFF: begin
              decim_next[rb] = decimation;
              scnt_next[rb]  = CNT_W'(1);
              mk_we          = 1'b1;
              mk_waddr       = {rb, {IDX_W{1'b0}}};
              mk_wdata       = POS_W'(1);
              rec_next       = dbtt_pkg::REC_ACTIVE;
            end
            dbtt_pkg::REC_ACTIVE: begin
              vcnt_next[rb]              = rhead;
              pend_next                  = 1'b1;
              s1_next.res.rec_head_clear = 1'b1;
              rec_next                   = dbtt_pkg::REC_RETAKE;
            end
            default: ;
          endcase
        end
        dbtt_pkg::CMD_STOP_REC: begin
          if (rec_st == dbtt_pkg::REC_ACTIVE) begin
            vcnt_next[rb]              = rhead;
            pend_next                  = 1'b1;
            s1_next.res.rec_head_clear = 1'b1;
            rec_next                   = dbtt_pkg::REC_TAKEN;
          end
        end
        dbtt_pkg::CMD_SLICE: begin
          if (rec_st == dbtt_pkg::REC_ACTIVE && nmark < CNT_W'(SLICE_SLOTS)) begin
            mk_we         = 1'b1;
            mk_waddr      = {rb, IDX_W'(nmark)};
            mk_wdata      = rhead;
            scnt_next[rb] = nmark + CNT_W'(1);
          end
        end
        default: ;
      endcase
    end

    // slice index on the playback bank after any swap
    cnt  = scnt[pb_next];
    cm1  = cnt - CNT_W'(1);
    prod = PROD_W'(it.slice_sel) * PROD_W'(cm1);
    vidx = prod >> 16;
    idx  = (cnt == '0) ? '0 :
           (vidx > PROD_W'(cm1)) ? IDX_W'(cm1) : IDX_W'(vidx);
    rd_addr = {pb_next, idx};

    s1_next.none  = (cnt == '0);
    s1_next.valid = vcnt[pb_next];

    s1_next.res.playing       = (play_next == dbtt_pkg::PLAY_RUNNING);
    s1_next.res.playback_bank = pb_next;
    s1_next.res.play_decimation = decim_next[pb_next];
    case (rec_next)
      dbtt_pkg::REC_OFF:    s1_next.res.rec_phase = dbtt_pkg::REC_CODE_IDLE;
      dbtt_pkg::REC_ACTIVE: s1_next.res.rec_phase = dbtt_pkg::REC_CODE_REC;
      dbtt_pkg::REC_TAKEN:  s1_next.res.rec_phase = dbtt_pkg::REC_CODE_DONE;
      dbtt_pkg::REC_RETAKE: s1_next.res.rec_phase = dbtt_pkg::REC_CODE_REREC;
      default:              s1_next.res.rec_phase = dbtt_pkg::REC_CODE_IDLE;
    endcase
  end

  // stage 1: slice guard on the mark just read
  always_comb begin
    res_d = s1.res;
    sp    = s1.none ? '0 : rd_data;
    if (sp == '0) sp = POS_W'(1);
    if (s1.place && sp < s1.valid &&
        (s1.valid - sp) >= POS_W'(dbtt_pkg::MIN_PLAY_LEN)) begin
      res_d.head_set = 1'b1;
      res_d.head_pos = sp;
    end
  end

  always_ff @(posedge clk) begin
    if (mk_we) marks[mk_waddr] <= mk_wdata;
    if (adv) rd_data <= marks[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      play_st      <= dbtt_pkg::PLAY_HALTED;
      rec_st       <= dbtt_pkg::REC_OFF;
      swap_pending <= 1'b0;
      play_bank    <= 1'b0;
      for (int b = 0; b < 2; b++) begin
        vcnt[b]       <= '0;
        decim_bank[b] <= '0;
        scnt[b]       <= '0;
      end
      reverse      <= 1'b0;
      decimation   <= '0;
      s1_valid     <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      play_st      <= play_next;
      rec_st       <= rec_next;
      swap_pending <= pend_next;
      play_bank    <= pb_next;
      for (int b = 0; b < 2; b++) begin
        vcnt[b]       <= vcnt_next[b];
        decim_bank[b] <= decim_next[b];
        scnt[b]       <= scnt_next[b];
      end
      if (cfg_we) begin
        case (cfg_index)
          dbtt_pkg::CFG_REVERSE:    reverse <= cfg_data[0];
          dbtt_pkg::CFG_DECIMATION: decimation <=
            (cfg_data > dbtt_pkg::DECIM_W'(dbtt_pkg::DECIM_MAX)) ?
            dbtt_pkg::DECIM_W'(dbtt_pkg::DECIM_MAX) : cfg_data;
          default: ;
        endcase
      end
      if (adv) begin
        s1_valid  <= accept;
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1    <= s1_next;
      res_q <= res_d;
    end
  end

  a_head_note: assert property (@(posedge clk) disable iff (rst)
    out_valid && res_q.head_set |-> res_q.note_on)
    else $error("head placed without note on");

  a_swap_clear: assert property (@(posedge clk) disable iff (rst)
    out_valid && res_q.bank_swapped |-> res_q.rec_head_clear)
    else $error("bank swap without record head clear");

  a_xfade_play: assert property (@(posedge clk) disable iff (rst)
    out_valid && res_q.xfade_arm |-> res_q.playing && res_q.note_on)
    else $error("crossfade armed while not playing");

  a_slice_cnt: assert property (@(posedge clk) disable iff (rst)
    scnt[0] <= CNT_W'(SLICE_SLOTS) && scnt[1] <= CNT_W'(SLICE_SLOTS))
    else $error("slice count beyond slot count");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !adv |=> s1_valid && $stable(s1))
    else $error("middle stage lost during stall");

endmodule
